// ===== sv/chtab_pkg.sv =====
`default_nettype none

package chtab_pkg;

    localparam int MAX_ENTRIES  = 256;
    localparam int MAX_CODE_LEN = 16;

    localparam int SYM_W  = 8;
    localparam int CODE_W = 16;
    localparam int LEN_W  = 5;
    localparam int IDX_W  = $clog2(MAX_ENTRIES);
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int LIDX_W = $clog2(MAX_CODE_LEN);
    localparam int NSYM   = 2 ** SYM_W;
    localparam int MAP_W  = CODE_W + LEN_W;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_LOAD   = 2'd1,
        OP_DECODE = 2'd2,
        OP_ENCODE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_BAD_LOAD  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_BUSY = 2'b10
    } t_state;

endpackage

`default_nettype wire

// ===== sv/chtab_ram.sv =====
`default_nettype none

module chtab_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/canonical_huffman_table.sv =====
`default_nettype none

// Channel  Handshake                 Payload
// in       i_in_valid / o_in_stall   i_op, i_code_len, i_symbol, i_code_bits
// out      o_out_valid / i_out_stall o_status, o_symbol_out, o_code_out, o_code_len_out
//
// The accepting edge of a transaction updates the table and issues one read of
// the entry RAM (decode) or the symbol map RAM (encode); the result is placed in
// the output register from S_BUSY once the output is free (not valid or not stalled).
// A new transaction is accepted while a finished result waits on a stalled output.
// Reset and a clear transaction empty the table at once; no clearing pass is needed.

module canonical_huffman_table (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire chtab_pkg::t_op                i_op,
    input  wire logic [chtab_pkg::LEN_W-1:0]   i_code_len,
    input  wire logic [chtab_pkg::SYM_W-1:0]   i_symbol,
    input  wire logic [chtab_pkg::CODE_W-1:0]  i_code_bits,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output chtab_pkg::t_status                 o_status,
    output logic      [chtab_pkg::SYM_W-1:0]   o_symbol_out,
    output logic      [chtab_pkg::CODE_W-1:0]  o_code_out,
    output logic      [chtab_pkg::LEN_W-1:0]   o_code_len_out
);

    import chtab_pkg::*;

    t_state              r_state;
    logic                r_out_valid;
    t_status             r_out_status;
    logic [SYM_W-1:0]    r_out_sym;
    logic [CODE_W-1:0]   r_out_code;
    logic [LEN_W-1:0]    r_out_len;

    t_op                 r_op;
    t_status             r_status;
    logic [SYM_W-1:0]    r_sym;
    logic [CODE_W-1:0]   r_code;
    logic [LEN_W-1:0]    r_len;

    t_status             n_status;
    logic [SYM_W-1:0]    n_sym;
    logic [CODE_W-1:0]   n_code;
    logic [LEN_W-1:0]    n_len;

    logic [CODE_W:0]     r_next_code;
    logic [LEN_W-1:0]    r_cur_len;
    logic [CNT_W-1:0]    r_entry_count;
    logic                r_loaded;
    logic [NSYM-1:0]     r_map_valid;
    logic [IDX_W-1:0]    r_first_idx  [MAX_CODE_LEN];
    logic [CNT_W-1:0]    r_count      [MAX_CODE_LEN];
    logic [CODE_W-1:0]   r_first_code [MAX_CODE_LEN];

    logic                acc;
    logic                len_bad;
    logic [LIDX_W-1:0]   li;
    logic                load_bad;
    logic                overflow;
    logic [LEN_W-1:0]    shift;
    logic [CODE_W:0]     shifted;
    logic [CODE_W-1:0]   new_code;
    logic                load_ok;
    logic [CODE_W:0]     diff;
    logic                hit;
    logic [IDX_W-1:0]    dec_idx;
    logic [SYM_W-1:0]    ent_rd;
    logic [MAP_W-1:0]    map_rd;
    logic                out_free;

    assign acc      = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    assign len_bad  = (i_code_len == '0) || (i_code_len > LEN_W'(MAX_CODE_LEN));
    assign li       = LIDX_W'(i_code_len - LEN_W'(1));
    assign shift    = i_code_len - r_cur_len;
    assign shifted  = r_next_code << shift;
    assign overflow = (r_entry_count != '0) && ((r_next_code >> r_cur_len) != '0);
    assign new_code = (r_entry_count == '0) ? '0 : shifted[CODE_W-1:0];
    assign load_bad = len_bad || (r_entry_count >= CNT_W'(MAX_ENTRIES))
                   || ((r_entry_count != '0) && (i_code_len < r_cur_len)) || overflow;
    assign load_ok  = acc && (i_op == OP_LOAD) && !load_bad;

    assign diff     = {1'b0, i_code_bits} - {1'b0, r_first_code[li]};
    assign hit      = !diff[CODE_W] && (diff < (CODE_W + 1)'(r_count[li]));
    assign dec_idx  = r_first_idx[li] + diff[IDX_W-1:0];

    chtab_ram #(
        .DEPTH (MAX_ENTRIES),
        .WIDTH (SYM_W)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (load_ok),
        .i_waddr (r_entry_count[IDX_W-1:0]),
        .i_wdata (i_symbol),
        .i_re    (acc && (i_op == OP_DECODE)),
        .i_raddr (dec_idx),
        .o_rdata (ent_rd)
    );

    chtab_ram #(
        .DEPTH (NSYM),
        .WIDTH (MAP_W)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (load_ok),
        .i_waddr (i_symbol),
        .i_wdata ({new_code, i_code_len}),
        .i_re    (acc && (i_op == OP_ENCODE)),
        .i_raddr (i_symbol),
        .o_rdata (map_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_code   <= '0;
            r_cur_len     <= '0;
            r_entry_count <= '0;
            r_loaded      <= 1'b0;
            r_map_valid   <= '0;
            for (int i = 0; i < MAX_CODE_LEN; i++) begin
                r_first_idx[i]  <= '0;
                r_count[i]      <= '0;
                r_first_code[i] <= '0;
            end
        end else if (acc && (i_op == OP_CLEAR)) begin
            r_next_code   <= '0;
            r_cur_len     <= '0;
            r_entry_count <= '0;
            r_loaded      <= 1'b0;
            r_map_valid   <= '0;
            for (int i = 0; i < MAX_CODE_LEN; i++) begin
                r_first_idx[i]  <= '0;
                r_count[i]      <= '0;
                r_first_code[i] <= '0;
            end
        end else if (load_ok) begin
            if (r_count[li] == '0) begin
                r_first_idx[li]  <= r_entry_count[IDX_W-1:0];
                r_first_code[li] <= new_code;
            end
            r_count[li]            <= r_count[li] + CNT_W'(1);
            r_map_valid[i_symbol]  <= 1'b1;
            r_next_code            <= {1'b0, new_code} + (CODE_W + 1)'(1);
            r_cur_len              <= i_code_len;
            r_entry_count          <= r_entry_count + CNT_W'(1);
            r_loaded               <= 1'b1;
        end
    end

    always_comb begin
        n_status = STAT_OK;
        n_sym    = '0;
        n_code   = '0;
        n_len    = '0;
        case (i_op)
            OP_CLEAR: begin
                n_status = STAT_OK;
            end
            OP_LOAD: begin
                if (load_bad) begin
                    n_status = STAT_BAD_LOAD;
                end else begin
                    n_sym  = i_symbol;
                    n_code = new_code;
                    n_len  = i_code_len;
                end
            end
            OP_DECODE: begin
                if (!r_loaded) begin
                    n_status = STAT_EMPTY;
                end else if (len_bad || !hit) begin
                    n_status = STAT_NOT_FOUND;
                end else begin
                    n_code = i_code_bits;
                    n_len  = i_code_len;
                end
            end
            default: begin
                if (!r_loaded) begin
                    n_status = STAT_EMPTY;
                end else if (!r_map_valid[i_symbol]) begin
                    n_status = STAT_NOT_FOUND;
                end else begin
                    n_sym = i_symbol;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_op     <= i_op;
            r_status <= n_status;
            r_sym    <= n_sym;
            r_code   <= n_code;
            r_len    <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_state <= S_BUSY;
                    end
                    if (r_out_valid && !i_out_stall) begin
                        r_out_valid <= 1'b0;
                    end
                end
                S_BUSY: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state     <= S_IDLE;
                    r_out_valid <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_BUSY) && out_free) begin
            r_out_status <= r_status;
            if ((r_status == STAT_OK) && (r_op == OP_DECODE)) begin
                r_out_sym <= ent_rd;
            end else begin
                r_out_sym <= r_sym;
            end
            if ((r_status == STAT_OK) && (r_op == OP_ENCODE)) begin
                r_out_code <= map_rd[MAP_W-1:LEN_W];
                r_out_len  <= map_rd[LEN_W-1:0];
            end else begin
                r_out_code <= r_code;
                r_out_len  <= r_len;
            end
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_symbol_out   = r_out_sym;
    assign o_code_out     = r_out_code;
    assign o_code_len_out = r_out_len;

endmodule

`default_nettype wire
